@@ hdl/fdfa_pkg.sv @@
package fdfa_pkg;

  // Fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int ID_W       = 16;
  localparam int KIND_W     = 2;
  localparam int AIDX_W     = 3;
  localparam int WCNT_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int AIU_W      = 4;
  localparam int TICKS_W    = 16;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK     = 2'd2;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_QUEUED   = 2'd0;
  localparam logic [KIND_W-1:0] EV_DROPPED  = 2'd1;
  localparam logic [KIND_W-1:0] EV_ASSIGNED = 2'd2;
  localparam logic [KIND_W-1:0] EV_FINISHED = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AGENTS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TICKS = 2'd1;

  // Register reset values
  localparam logic [AIU_W-1:0]   AIU_RESET   = 4'd3;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DISP,
    ST_TICK
  } state_t;

  typedef struct packed {
    logic load_in;
    logic add_exec;
    logic disp_step;
    logic tick_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic lim_zero;
    logic disp_ok;
    logic disp_end;
    logic tick_ok;
    logic tick_end;
  } dp_sts_t;

endpackage

@@ hdl/fdfa_if.sv @@
interface fdfa_req_if
  import fdfa_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_W-1:0]     request_id;

  modport source (output valid, output opcode, output request_id, input ready);
  modport sink   (input valid, input opcode, input request_id, output ready);
endinterface

interface fdfa_rsp_if
  import fdfa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [AIDX_W-1:0] agent_index;
  logic [ID_W-1:0]   served_id;
  logic              last_of_run;
  logic [WCNT_W-1:0] waiting_count;

  modport source (output valid, output event_kind, output agent_index, output served_id,
                  output last_of_run, output waiting_count, input ready);
  modport sink   (input valid, input event_kind, input agent_index, input served_id,
                  input last_of_run, input waiting_count, output ready);
endinterface

interface fdfa_cfg_if
  import fdfa_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/fdfa_ctrl.sv @@
module fdfa_ctrl
  import fdfa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] in_opcode,
  output logic                in_ready,
  input  dp_sts_t             sts,
  output dp_cmd_t             cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_opcode == OP_ADD) begin
            state_next = ST_ADD;
          end else if (in_opcode == OP_DISPATCH) begin
            state_next = sts.lim_zero ? ST_IDLE : ST_DISP;
          end else if (in_opcode == OP_TICK) begin
            state_next = ST_TICK;
          end
        end
      end
      ST_ADD: begin
        if (sts.out_free) begin
          cmd.add_exec = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_DISP: begin
        if (sts.disp_ok) begin
          cmd.disp_step = 1'b1;
          if (sts.disp_end) state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (sts.tick_ok) begin
          cmd.tick_step = 1'b1;
          if (sts.tick_end) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.add_exec, cmd.disp_step, cmd.tick_step}))
    else $error("more than one datapath step in a cycle");

  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.disp_step && sts.disp_end) || (cmd.tick_step && sts.tick_end)
      |=> state == ST_IDLE)
    else $error("scan did not return to idle at its last agent");
`endif

endmodule

@@ hdl/fdfa_datapath.sv @@
module fdfa_datapath
  import fdfa_pkg::*;
#(
  parameter int MAX_AGENTS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // input beat payload
  input  logic [ID_W-1:0]       in_request_id,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result register
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_kind,
  output logic [AIDX_W-1:0]     out_agent,
  output logic [ID_W-1:0]       out_id,
  output logic                  out_last,
  output logic [WCNT_W-1:0]     out_wcount,
  // controller link
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts
);

  localparam int IDX_W = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W = 6;

  logic [AIU_W-1:0]   agents_in_use;
  logic [TICKS_W-1:0] service_ticks;
  logic [ID_W-1:0]    req_id;
  logic [IDX_W-1:0]   idx;
  logic [PTR_W-1:0]   head, head_next, tail;
  logic [CNT_W-1:0]   fill;
  logic [ID_W-1:0]    mem [QUEUE_DEPTH];
  logic [ID_W-1:0]    rd_data;

  logic [MAX_AGENTS-1:0] busy;
  logic [TICKS_W-1:0]    time_left [MAX_AGENTS];
  logic [ID_W-1:0]       agent_req [MAX_AGENTS];

  logic [LIM_W-1:0]      lim, idx_ext;
  logic [TICKS_W-1:0]    ticks;
  logic                  full, empty, disp_hit, tick_hit, disp_last, tick_last, out_free;
  logic [MAX_AGENTS-1:0] free_above, fin_above, stale;
  logic [PTR_W-1:0]      head_inc, tail_inc;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      agents_in_use <= AIU_RESET;
      service_ticks <= TICKS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_AGENTS_IN_USE) agents_in_use <= cfg_data[AIU_W-1:0];
      if (cfg_index == REG_SERVICE_TICKS) service_ticks <= cfg_data[TICKS_W-1:0];
    end
  end

  assign lim = ({{(LIM_W-AIU_W){1'b0}}, agents_in_use} > LIM_W'(MAX_AGENTS))
             ? LIM_W'(MAX_AGENTS) : {{(LIM_W-AIU_W){1'b0}}, agents_in_use};
  assign ticks   = (service_ticks == '0) ? TICKS_W'(1) : service_ticks;
  assign idx_ext = LIM_W'(idx);
  assign full    = fill == CNT_W'(QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign out_free = !out_valid || out_ready;

  assign head_inc = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
  assign tail_inc = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + PTR_W'(1);

  assign disp_hit = !busy[idx] && !empty;
  assign tick_hit = busy[idx] && (time_left[idx] <= TICKS_W'(1));

  always_comb begin
    for (int j = 0; j < MAX_AGENTS; j++) begin
      free_above[j] = !busy[j] && (LIM_W'(j) < lim) && (LIM_W'(j) > idx_ext);
      fin_above[j]  = busy[j] && (time_left[j] <= TICKS_W'(1)) && (LIM_W'(j) > idx_ext);
      stale[j]      = busy[j] && (time_left[j] == '0);
    end
  end

  assign disp_last = (fill == CNT_W'(1)) || (free_above == '0);
  assign tick_last = fin_above == '0;

  assign sts.out_free = out_free;
  assign sts.lim_zero = lim == '0;
  assign sts.disp_ok  = !disp_hit || out_free;
  assign sts.disp_end = (idx_ext + LIM_W'(1)) == lim;
  assign sts.tick_ok  = !tick_hit || out_free;
  assign sts.tick_end = idx == IDX_W'(MAX_AGENTS - 1);

  assign head_next = (cmd.disp_step && disp_hit) ? head_inc : head;

  // wait store: written at tail, read data tracks the head
  always_ff @(posedge clk) begin
    if (cmd.add_exec && !full) mem[tail] <= req_id;
    rd_data <= mem[head_next];
  end

  // FIFO pointers and scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
      idx  <= '0;
    end else begin
      head <= head_next;
      if (cmd.add_exec && !full) begin
        tail <= tail_inc;
        fill <= fill + CNT_W'(1);
      end else if (cmd.disp_step && disp_hit) begin
        fill <= fill - CNT_W'(1);
      end
      if (cmd.load_in) begin
        idx <= '0;
      end else if (cmd.disp_step || cmd.tick_step) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) req_id <= in_request_id;
  end

  // agents
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int j = 0; j < MAX_AGENTS; j++) time_left[j] <= '0;
    end else if (cmd.disp_step && disp_hit) begin
      busy[idx]      <= 1'b1;
      time_left[idx] <= ticks;
    end else if (cmd.tick_step && busy[idx]) begin
      if (time_left[idx] != '0) time_left[idx] <= time_left[idx] - TICKS_W'(1);
      if (tick_hit) busy[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.disp_step && disp_hit) agent_req[idx] <= rd_data;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.add_exec || (cmd.disp_step && disp_hit) || (cmd.tick_step && tick_hit)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_exec) begin
      out_kind   <= full ? EV_DROPPED : EV_QUEUED;
      out_agent  <= '0;
      out_id     <= req_id;
      out_last   <= 1'b1;
      out_wcount <= full ? WCNT_W'(fill) : WCNT_W'(fill + CNT_W'(1));
    end else if (cmd.disp_step && disp_hit) begin
      out_kind   <= EV_ASSIGNED;
      out_agent  <= AIDX_W'(idx);
      out_id     <= rd_data;
      out_last   <= disp_last;
      out_wcount <= WCNT_W'(fill - CNT_W'(1));
    end else if (cmd.tick_step && tick_hit) begin
      out_kind   <= EV_FINISHED;
      out_agent  <= AIDX_W'(idx);
      out_id     <= agent_req[idx];
      out_last   <= tick_last;
      out_wcount <= WCNT_W'(fill);
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> head == tail)
    else $error("pointers disagree with fill count");

  a_busy_time: assert property (@(posedge clk) disable iff (rst)
    stale == '0)
    else $error("busy agent with no time left");
`endif

endmodule

@@ hdl/fifo_dispatch_to_free_agents.sv @@
// Channel  Modport  Fields                                          Beat when
// req      sink     opcode, request_id                              valid && ready
// rsp      source   event_kind, agent_index, served_id,             valid && ready
//                   last_of_run, waiting_count
// cfg      sink     index, data                                     valid && ready (ready tied 1)
//
// No-op: accept. Add: accept, result load. Dispatch: accept, scan agents in use.
// Tick: accept, scan all agents. The scan steps one agent per cycle unless stalled.
// One item is in work at a time; the next is accepted while the last result waits.
// Reset (rst, synchronous): FIFO empty, agents free, registers at 3 and 5.
// Stalls: an add, or a scan step that produces a result, waits while rsp holds an
// untaken beat.
module fifo_dispatch_to_free_agents
  import fdfa_pkg::*;
#(
  parameter int MAX_AGENTS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  fdfa_req_if.sink  req,
  fdfa_rsp_if.source rsp,
  fdfa_cfg_if.sink  cfg
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // config writes always taken; the source must send them only while the block is idle; the block does not enforce this
  assign cfg.ready = 1'b1;

  fdfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_opcode (req.opcode),
    .in_ready  (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fdfa_datapath #(
    .MAX_AGENTS  (MAX_AGENTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_request_id (req.request_id),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_kind      (rsp.event_kind),
    .out_agent     (rsp.agent_index),
    .out_id        (rsp.served_id),
    .out_last      (rsp.last_of_run),
    .out_wcount    (rsp.waiting_count),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
